### sv/ctmi_pkg.sv
// ctmi_pkg: shared constants, codes and types of the tile map interpolator
// used by every module of the block; no dependencies
`default_nettype none
package ctmi_pkg;
	localparam int TILES_X_DEF = 8;
	localparam int TILES_Y_DEF = 8;
	localparam int MAX_TILES = 16;
	localparam int LEVELS = 256;
	localparam int LEVEL_W = 8;
	localparam int PIX_W = 8;
	localparam int TILE_W = 4;
	localparam int TROW_W = 3;
	localparam int CNT_W = 5;
	localparam int POS_W = 12;
	localparam int SIZE_W = 10;
	localparam int CENTRE_W = 14;
	localparam int FRAC_BITS = 24;
	localparam int COEFF_W = 25;
	localparam int WEIGHT_W = 24;
	localparam int DIV_STEPS = 25;
	localparam int STEP_W = 5;
	localparam int CFG_IDX_W = 4;
	localparam int SIZE_RESET = 64;
	localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'((1 << FRAC_BITS) / (SIZE_RESET + 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TILE_WIDTH  = 4'd0,
		CFG_TILE_HEIGHT = 4'd1
	} cfg_reg_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [TILE_W-1:0] lo;
		logic [TILE_W-1:0] hi;
		logic [SIZE_W-1:0] offs;
	} band_t;
endpackage
`default_nettype wire

### sv/ctmi_recip.sv
// ctmi_recip: bit-serial reciprocal floor(2^24 / (size + 1)), one quotient bit per cycle
// depends on ctmi_pkg
`default_nettype none
module ctmi_recip
	import ctmi_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic [SIZE_W-1:0]  size,
	output logic                    busy,
	output logic [COEFF_W-1:0]      coeff
);
	logic [SIZE_W:0]   div_q;
	logic [SIZE_W:0]   rem_q;
	logic [COEFF_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [SIZE_W+1:0] trial;
	logic              qbit;

	always_comb begin
		trial = {rem_q, step_q == STEP_W'(DIV_STEPS)};
		qbit = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			quo_q <= COEFF_RESET;
		end else if (load) begin
			step_q <= STEP_W'(DIV_STEPS);
			quo_q <= '0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			quo_q <= {quo_q[COEFF_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			div_q <= {1'b0, size} + 1'b1;
			rem_q <= '0;
		end else if (step_q != '0) begin
			rem_q <= qbit ? (SIZE_W+1)'(trial - {1'b0, div_q}) : trial[SIZE_W:0];
		end
	end

	assign busy = step_q != '0;
	assign coeff = quo_q;
endmodule
`default_nettype wire

### sv/ctmi_band.sv
// ctmi_band: per-axis band finder, two stages: centre compare count, then tiles and distance
// depends on ctmi_pkg
`default_nettype none
module ctmi_band
	import ctmi_pkg::*;
#(
	parameter int TILES = TILES_X_DEF
) (
	input  wire logic              clk,
	input  wire logic [SIZE_W-1:0] size,
	input  wire logic [POS_W-1:0]  pos_s1,
	output band_t                  band_s3
);
	logic [CENTRE_W-1:0] centre_q [MAX_TILES];
	logic [CNT_W-1:0]    cnt;
	logic [CNT_W-1:0]    cnt_s2;
	logic [POS_W-1:0]    pos_s2;
	logic [TILE_W-1:0]   idx;
	logic [CENTRE_W-1:0] diff;
	logic                at_edge;
	band_t               band;

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_TILES; j++) begin
			centre_q[j] <= CENTRE_W'(j) * {4'b0, size} + {5'b0, size[SIZE_W-1:1]};
		end
	end

	// number of centres at or left of the pixel
	always_comb begin
		cnt = '0;
		for (int j = 0; j < TILES; j++) begin
			cnt = cnt + CNT_W'({2'b0, pos_s1} >= centre_q[j]);
		end
	end

	always_ff @(posedge clk) begin
		cnt_s2 <= cnt;
		pos_s2 <= pos_s1;
	end

	always_comb begin
		at_edge = (cnt_s2 == '0) || (cnt_s2 == CNT_W'(TILES));
		idx = TILE_W'(cnt_s2 - 1'b1);
		diff = {2'b0, pos_s2} - centre_q[idx];
		if (cnt_s2 == '0) begin
			band.lo = '0;
			band.hi = '0;
		end else if (at_edge) begin
			band.lo = TILE_W'(TILES - 1);
			band.hi = TILE_W'(TILES - 1);
		end else begin
			band.lo = idx;
			band.hi = cnt_s2[TILE_W-1:0];
		end
		band.offs = at_edge ? '0 : diff[SIZE_W-1:0];
	end

	always_ff @(posedge clk) begin
		band_s3 <= band;
	end
endmodule
`default_nettype wire

### sv/ctmi_map_mem.sv
// ctmi_map_mem: mapping tables in four banks by tile row and column parity
// one write and one registered read per bank per cycle; depends on ctmi_pkg
`default_nettype none
module ctmi_map_mem
	import ctmi_pkg::*;
#(
	parameter int TILES_X = TILES_X_DEF,
	parameter int TILES_Y = TILES_Y_DEF
) (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [TILE_W-1:0]  wr_row,
	input  wire logic [TILE_W-1:0]  wr_col,
	input  wire logic [LEVEL_W-1:0] level,
	input  wire logic [PIX_W-1:0]   wr_data,
	input  wire logic               rd_en,
	input  wire band_t              row_band,
	input  wire band_t              col_band,
	output logic [PIX_W-1:0]        ul,
	output logic [PIX_W-1:0]        ur,
	output logic [PIX_W-1:0]        dl,
	output logic [PIX_W-1:0]        dr
);
	localparam int BANK_ROWS = (TILES_Y + 1) / 2;
	localparam int BANK_COLS = (TILES_X + 1) / 2;
	localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS * LEVELS;
	localparam int AW = $clog2(BANK_DEPTH);

	logic [PIX_W-1:0] rd_q [4];
	logic [1:0]       sel_ul_s4, sel_ur_s4, sel_dl_s4, sel_dr_s4;

	function automatic logic [AW-1:0] bank_addr(logic [TILE_W-1:0] r, logic [TILE_W-1:0] c,
			logic [LEVEL_W-1:0] lv);
		logic [7:0] tidx;
		tidx = 8'(r[TILE_W-1:1]) * 8'(BANK_COLS) + 8'(c[TILE_W-1:1]);
		return AW'({tidx, lv});
	endfunction

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BSEL = 2'(b);
		logic [PIX_W-1:0]  mem [BANK_DEPTH];
		logic [TILE_W-1:0] rr, rc;
		logic              wsel;

		always_comb begin
			rr = (row_band.lo[0] == BSEL[1]) ? row_band.lo : row_band.hi;
			rc = (col_band.lo[0] == BSEL[0]) ? col_band.lo : col_band.hi;
			wsel = wr_en && (wr_row[0] == BSEL[1]) && (wr_col[0] == BSEL[0]);
		end

		always_ff @(posedge clk) begin
			if (wsel) begin
				mem[bank_addr(wr_row, wr_col, level)] <= wr_data;
			end
			if (rd_en) begin
				rd_q[b] <= mem[bank_addr(rr, rc, level)];
			end
		end
	end

	always_ff @(posedge clk) begin
		sel_ul_s4 <= {row_band.lo[0], col_band.lo[0]};
		sel_ur_s4 <= {row_band.lo[0], col_band.hi[0]};
		sel_dl_s4 <= {row_band.hi[0], col_band.lo[0]};
		sel_dr_s4 <= {row_band.hi[0], col_band.hi[0]};
	end

	assign ul = rd_q[sel_ul_s4];
	assign ur = rd_q[sel_ur_s4];
	assign dl = rd_q[sel_dl_s4];
	assign dr = rd_q[sel_dr_s4];
endmodule
`default_nettype wire

### sv/clahe_tile_map_interpolator_unit.sv
// clahe_tile_map_interpolator_unit: eight-stage pipeline, one request per cycle while not busy
// a pixel result is registered through stages s1 to s8 and flagged by done; a write gives none
// results are never held off by the receiver, so the pipeline itself never stalls
// after a tile size write, busy stays high while the reciprocal is computed
// reset: tile sizes return to 64 and valid bits clear; tables are undefined until written
// depends on ctmi_pkg, ctmi_recip, ctmi_band, ctmi_map_mem
`default_nettype none
module clahe_tile_map_interpolator_unit
	import ctmi_pkg::*;
#(
	parameter int TILES_X = TILES_X_DEF,
	parameter int TILES_Y = TILES_Y_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 command,
	input  wire logic [TROW_W-1:0]    tile_row,
	input  wire logic [TROW_W-1:0]    tile_col,
	input  wire logic [LEVEL_W-1:0]   level,
	input  wire logic [PIX_W-1:0]     map_value,
	input  wire logic [POS_W-1:0]     pixel_row,
	input  wire logic [POS_W-1:0]     pixel_col,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data,
	output logic                      done,
	output logic [PIX_W-1:0]          out_pixel
);
	logic [SIZE_W-1:0]  width_q, height_q;
	logic [COEFF_W-1:0] kw, kh;
	logic               busy_w, busy_h, load_w, load_h, accept;

	logic v_s1, v_s2, v_s3, pix_s4, pix_s5, pix_s6, pix_s7, done_s8;
	logic cmd_s1, cmd_s2, cmd_s3;
	logic [TROW_W-1:0]  trow_s1, trow_s2, trow_s3, tcol_s1, tcol_s2, tcol_s3;
	logic [LEVEL_W-1:0] lvl_s1, lvl_s2, lvl_s3;
	logic [PIX_W-1:0]   mval_s1, mval_s2, mval_s3;
	logic [POS_W-1:0]   prow_s1, pcol_s1;
	band_t              rb_s3, cb_s3;
	logic               wr_en;
	logic [PIX_W-1:0]   ul, ur, dl, dr;
	logic [COEFF_W+SIZE_W-1:0] wx_full, wy_full;
	logic [WEIGHT_W-1:0] wx_s4, wy_s4, wy_s5, wy_s6;
	logic signed [PIX_W:0]  dt, db, dv;
	logic signed [PIX_W+WEIGHT_W+1:0] pt, pb, pv, pt_s5, pb_s5, pv_s7;
	logic [PIX_W-1:0]   ul_s5, dl_s5, top_s6, bot_s6, top_s7, pixel_s8;
	logic signed [PIX_W+WEIGHT_W+1:0] top_c, bot_c, res_c;

	assign accept = start && !busy;
	assign busy = busy_w || busy_h;
	assign cfg_ready = !busy;
	assign load_w = cfg_valid && cfg_ready && (cfg_index == CFG_TILE_WIDTH);
	assign load_h = cfg_valid && cfg_ready && (cfg_index == CFG_TILE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_W'(SIZE_RESET);
			height_q <= SIZE_W'(SIZE_RESET);
		end else begin
			if (load_w) begin
				width_q <= cfg_data;
			end
			if (load_h) begin
				height_q <= cfg_data;
			end
		end
	end

	ctmi_recip u_recip_w (.clk, .arst_n, .load(load_w), .size(cfg_data), .busy(busy_w),
		.coeff(kw));
	ctmi_recip u_recip_h (.clk, .arst_n, .load(load_h), .size(cfg_data), .busy(busy_h),
		.coeff(kh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			pix_s4 <= 1'b0;
			pix_s5 <= 1'b0;
			pix_s6 <= 1'b0;
			pix_s7 <= 1'b0;
			done_s8 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			pix_s4 <= v_s3 && (cmd_s3 == CMD_PIXEL);
			pix_s5 <= pix_s4;
			pix_s6 <= pix_s5;
			pix_s7 <= pix_s6;
			done_s8 <= pix_s7;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= command;
		trow_s1 <= tile_row;
		tcol_s1 <= tile_col;
		lvl_s1 <= level;
		mval_s1 <= map_value;
		prow_s1 <= pixel_row;
		pcol_s1 <= pixel_col;
		cmd_s2 <= cmd_s1;
		trow_s2 <= trow_s1;
		tcol_s2 <= tcol_s1;
		lvl_s2 <= lvl_s1;
		mval_s2 <= mval_s1;
		cmd_s3 <= cmd_s2;
		trow_s3 <= trow_s2;
		tcol_s3 <= tcol_s2;
		lvl_s3 <= lvl_s2;
		mval_s3 <= mval_s2;
	end

	ctmi_band #(.TILES(TILES_Y)) u_band_row (.clk, .size(height_q), .pos_s1(prow_s1),
		.band_s3(rb_s3));
	ctmi_band #(.TILES(TILES_X)) u_band_col (.clk, .size(width_q), .pos_s1(pcol_s1),
		.band_s3(cb_s3));

	assign wr_en = v_s3 && (cmd_s3 == CMD_WRITE) && ({2'b0, trow_s3} < 5'(TILES_Y))
		&& ({2'b0, tcol_s3} < 5'(TILES_X));

	ctmi_map_mem #(.TILES_X(TILES_X), .TILES_Y(TILES_Y)) u_mem (
		.clk,
		.wr_en,
		.wr_row({1'b0, trow_s3}),
		.wr_col({1'b0, tcol_s3}),
		.level(lvl_s3),
		.wr_data(mval_s3),
		.rd_en(v_s3 && (cmd_s3 == CMD_PIXEL)),
		.row_band(rb_s3),
		.col_band(cb_s3),
		.ul, .ur, .dl, .dr
	);

	// blend weights: offset * coeff stays below 2^24
	assign wx_full = {{COEFF_W{1'b0}}, cb_s3.offs} * {{SIZE_W{1'b0}}, kw};
	assign wy_full = {{COEFF_W{1'b0}}, rb_s3.offs} * {{SIZE_W{1'b0}}, kh};

	always_ff @(posedge clk) begin
		wx_s4 <= wx_full[WEIGHT_W-1:0];
		wy_s4 <= wy_full[WEIGHT_W-1:0];
	end

	always_comb begin
		dt = $signed({1'b0, ur}) - $signed({1'b0, ul});
		db = $signed({1'b0, dr}) - $signed({1'b0, dl});
		pt = dt * $signed({1'b0, wx_s4});
		pb = db * $signed({1'b0, wx_s4});
	end

	always_ff @(posedge clk) begin
		pt_s5 <= pt;
		pb_s5 <= pb;
		ul_s5 <= ul;
		dl_s5 <= dl;
		wy_s5 <= wy_s4;
	end

	// arithmetic shift gives the floor also for negative differences
	always_comb begin
		top_c = $signed({{(WEIGHT_W+2){1'b0}}, ul_s5}) + (pt_s5 >>> FRAC_BITS);
		bot_c = $signed({{(WEIGHT_W+2){1'b0}}, dl_s5}) + (pb_s5 >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		top_s6 <= top_c[PIX_W-1:0];
		bot_s6 <= bot_c[PIX_W-1:0];
		wy_s6 <= wy_s5;
	end

	always_comb begin
		dv = $signed({1'b0, bot_s6}) - $signed({1'b0, top_s6});
		pv = dv * $signed({1'b0, wy_s6});
	end

	always_ff @(posedge clk) begin
		pv_s7 <= pv;
		top_s7 <= top_s6;
	end

	assign res_c = $signed({{(WEIGHT_W+2){1'b0}}, top_s7}) + (pv_s7 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		pixel_s8 <= res_c[PIX_W-1:0];
	end

	assign done = done_s8;
	assign out_pixel = pixel_s8;

`ifndef NO_ASSERTIONS
	a_busy_from_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(cfg_valid && cfg_ready
			&& (cfg_index == CFG_TILE_WIDTH || cfg_index == CFG_TILE_HEIGHT)))
		else $error("busy rose without a tile size write");
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (command == CMD_PIXEL), 8))
		else $error("result without a pixel request eight cycles earlier");
	a_no_cfg_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !pix_s4 || $past(busy))
		else $error("tile size changed while pixels in flight");
`endif
endmodule
`default_nettype wire
